### rtl/core/rlcs_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and register map of the led chain serializer
package rlcs_pkg;

	localparam int LED_DEPTH = 64;
	localparam int AW = (LED_DEPTH > 1) ? $clog2(LED_DEPTH) : 1;
	localparam int LW = $clog2(LED_DEPTH + 1);
	localparam int BITS_PER_LED = 24;
	localparam int BPW = $clog2(BITS_PER_LED);
	localparam int TICK_W = 16;

	localparam logic [7:0] ZERO_HIGH_RST = 8'd17;
	localparam logic [7:0] ONE_HIGH_RST = 8'd38;
	localparam logic [7:0] PERIOD_RST = 8'd60;
	localparam logic [15:0] GAP_RST = 16'd2880;

	typedef enum logic [1:0] {
		REG_ZERO_HIGH = 2'd0,
		REG_ONE_HIGH = 2'd1,
		REG_PERIOD = 2'd2,
		REG_GAP = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_SET = 2'd0,
		OP_SHOW = 2'd1,
		OP_CLEAR = 2'd2,
		OP_TICK = 2'd3
	} op_t;

	typedef struct packed {
		logic [15:0] gap;
		logic [7:0] period;
		logic [7:0] one_high;
		logic [7:0] zero_high;
	} cfg_t;

	typedef struct packed {
		logic set_px;
		logic clr_store;
		logic start;
		logic load;
		logic tick_send;
		logic tick_gap;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic frame_end;
		logic gap_end;
	} stat_t;

	typedef struct packed {
		logic frame_done;
		logic busy_res;
		logic line_level;
	} res_t;

endpackage

### rtl/core/rlcs_ctrl.sv
`timescale 1ns / 1ps
// frame sequencer: idle, store read, bit sending and latch gap
module rlcs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           acc,
	input  rlcs_pkg::op_t  op,
	input  rlcs_pkg::stat_t stat,
	output rlcs_pkg::cmd_t cmd,
	output logic           take_ok,
	output logic           busy,
	output logic           done
);
	import rlcs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WAIT,
		S_LOAD,
		S_SEND,
		S_GAP
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd = '0;
		done = 1'b0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					unique case (op)
						OP_SET: begin
							cmd.set_px = 1'b1;
						end
						OP_SHOW, OP_CLEAR: begin
							cmd.start = 1'b1;
							cmd.clr_store = (op == OP_CLEAR);
							state_nxt = stat.count_zero ? S_GAP : S_WAIT;
						end
						OP_TICK: begin
						end
					endcase
				end
			end
			// entry 0 is read into the data register during this cycle
			S_WAIT: begin
				state_nxt = S_LOAD;
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_nxt = S_SEND;
			end
			S_SEND: begin
				if (acc && op == OP_TICK) begin
					cmd.tick_send = 1'b1;
					if (stat.frame_end) begin
						state_nxt = S_GAP;
					end
				end
			end
			S_GAP: begin
				if (acc && op == OP_TICK) begin
					cmd.tick_gap = 1'b1;
					if (stat.gap_end) begin
						state_nxt = S_IDLE;
						done = 1'b1;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign take_ok = (state_q != S_WAIT) && (state_q != S_LOAD);
	assign busy = (state_nxt != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	a_wait_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WAIT |=> state_q == S_LOAD)
		else $error("store read wait not followed by load");

	a_no_take_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAIT || state_q == S_LOAD) |-> !acc)
		else $error("item taken during store read");

	a_done_ends_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == S_GAP && cmd.tick_gap) ##1 state_q == S_IDLE)
		else $error("frame done outside the end of the latch gap");

	a_start_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> state_q == S_IDLE)
		else $error("frame started while busy");

endmodule

### rtl/core/rlcs_dp.sv
`timescale 1ns / 1ps
// datapath: colour store, shift word and bit/gap timing counters
module rlcs_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  rlcs_pkg::cmd_t  cmd,
	input  rlcs_pkg::cfg_t  cfg,
	input  logic [7:0]      led_index,
	input  logic [7:0]      red,
	input  logic [7:0]      green,
	input  logic [7:0]      blue,
	input  logic [7:0]      led_count,
	output rlcs_pkg::stat_t stat,
	output logic            line_nxt
);
	import rlcs_pkg::*;

	logic [BITS_PER_LED-1:0] mem [LED_DEPTH];
	logic [LED_DEPTH-1:0]    valid_q;
	logic [BITS_PER_LED-1:0] rd_data_q;
	logic                    rd_ok_q;

	logic [BITS_PER_LED-1:0] shift_q;
	logic [LW-1:0]           led_q;
	logic [LW-1:0]           frame_len_q;
	logic [BPW-1:0]          bit_pos_q;
	logic [TICK_W-1:0]       tick_q;
	logic                    line_q;

	logic [AW-1:0]           wr_addr;
	logic [AW-1:0]           rd_addr;
	logic                    idx_ok;
	logic                    rd_in_range;
	logic [LW-1:0]           count_cl;
	logic [BITS_PER_LED-1:0] word;
	logic [7:0]              high;
	logic                    high_now;
	logic [TICK_W:0]         tick_nxt;
	logic                    bit_wrap;
	logic                    led_wrap;
	logic                    led_end;

	assign wr_addr = led_index[AW-1:0];
	assign idx_ok = {1'b0, led_index} < 9'(LED_DEPTH);
	assign rd_addr = led_q[AW-1:0];
	assign rd_in_range = led_q < LW'(LED_DEPTH);
	assign count_cl = ({1'b0, led_count} > 9'(LED_DEPTH)) ? LW'(LED_DEPTH) : LW'(led_count);
	// entries never written since reset or clear read as black
	assign word = rd_ok_q ? rd_data_q : '0;

	assign high = shift_q[BITS_PER_LED-1] ? cfg.one_high : cfg.zero_high;
	assign high_now = tick_q < TICK_W'(high);
	assign tick_nxt = {1'b0, tick_q} + (TICK_W+1)'(1);
	assign bit_wrap = tick_nxt >= (TICK_W+1)'(cfg.period);
	assign led_wrap = bit_wrap && (bit_pos_q == BPW'(BITS_PER_LED - 1));
	assign led_end = led_q >= frame_len_q;

	assign stat.count_zero = (led_count == 8'd0);
	assign stat.frame_end = led_wrap && led_end;
	// a zero gap behaves as one tick, since every count is at or above it
	assign stat.gap_end = (tick_nxt >= {1'b0, cfg.gap}) || (tick_nxt[TICK_W-1:0] == '0);

	always_comb begin
		if (cmd.tick_send) begin
			line_nxt = high_now;
		end else if (cmd.tick_gap || cmd.start) begin
			line_nxt = 1'b0;
		end else begin
			line_nxt = line_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_px && idx_ok) begin
			mem[wr_addr] <= {green, red, blue};
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (cmd.clr_store) begin
				valid_q <= '0;
			end else if (cmd.set_px && idx_ok) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_ok_q <= rd_in_range && valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			led_q <= '0;
			frame_len_q <= '0;
			bit_pos_q <= '0;
			tick_q <= '0;
			line_q <= 1'b0;
		end else begin
			line_q <= line_nxt;
			if (cmd.start) begin
				frame_len_q <= count_cl;
				led_q <= '0;
				bit_pos_q <= '0;
				tick_q <= '0;
				shift_q <= '0;
			end else if (cmd.load) begin
				shift_q <= word;
				led_q <= LW'(1);
			end else if (cmd.tick_send) begin
				if (bit_wrap) begin
					tick_q <= '0;
					if (led_wrap) begin
						bit_pos_q <= '0;
						if (led_end) begin
							shift_q <= '0;
							led_q <= '0;
						end else begin
							// next entry was prefetched while this led was sent
							shift_q <= word;
							led_q <= led_q + LW'(1);
						end
					end else begin
						bit_pos_q <= bit_pos_q + BPW'(1);
						shift_q <= {shift_q[BITS_PER_LED-2:0], 1'b0};
					end
				end else begin
					tick_q <= tick_nxt[TICK_W-1:0];
				end
			end else if (cmd.tick_gap) begin
				tick_q <= stat.gap_end ? '0 : tick_nxt[TICK_W-1:0];
			end
		end
	end

	a_bit_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_pos_q <= BPW'(BITS_PER_LED - 1))
		else $error("bit position past end of led");

	a_frame_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		frame_len_q <= LW'(LED_DEPTH))
		else $error("frame length above store depth");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_store |=> valid_q == '0)
		else $error("store not empty after clear");

endmodule

### rtl/core/rgb_led_chain_serializer_core.sv
`timescale 1ns / 1ps
// top level: stream ports, config registers, output skid and core units
// the result of an item is registered for m_tdata, held in the skid entry first if the output is stalled
// one item per cycle while the skid entry is empty; a show or clear that sends leds holds s_tready low
//   in the wait and load states while entry 0 is read from the store memory
// reset clears the config to defaults, the store valid bits (store reads as black),
//   the sequencer to idle and the output stage; no clearing pass is needed
module rgb_led_chain_serializer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // op[1:0], led_index, red, green, blue, led_count, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // line_level, busy_res, frame_done, zero pad
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import rlcs_pkg::*;

	cfg_t     cfg_q;
	res_t     out_q;
	res_t     skid_q;
	logic     out_v_q;
	logic     skid_v_q;

	logic     acc;
	logic     pop;
	logic     take_ok;
	logic     busy;
	logic     done;
	logic     line_nxt;
	logic     cfg_wr;
	reg_idx_t reg_sel;
	op_t      op;
	cmd_t     cmd;
	stat_t    stat;
	res_t     res;

	assign op = op_t'(s_tdata[1:0]);
	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		unique case (reg_sel)
			REG_ZERO_HIGH: prdata = {24'd0, cfg_q.zero_high};
			REG_ONE_HIGH:  prdata = {24'd0, cfg_q.one_high};
			REG_PERIOD:    prdata = {24'd0, cfg_q.period};
			REG_GAP:       prdata = {16'd0, cfg_q.gap};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_high <= ZERO_HIGH_RST;
			cfg_q.one_high <= ONE_HIGH_RST;
			cfg_q.period <= PERIOD_RST;
			cfg_q.gap <= GAP_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_ZERO_HIGH: cfg_q.zero_high <= pwdata[7:0];
				REG_ONE_HIGH:  cfg_q.one_high <= pwdata[7:0];
				REG_PERIOD:    cfg_q.period <= pwdata[7:0];
				REG_GAP:       cfg_q.gap <= pwdata[15:0];
			endcase
		end
	end

	assign s_tready = take_ok && !skid_v_q;
	assign acc = s_tvalid && s_tready;
	assign pop = out_v_q && m_tready;

	rlcs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.op      (op),
		.stat    (stat),
		.cmd     (cmd),
		.take_ok (take_ok),
		.busy    (busy),
		.done    (done)
	);

	rlcs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg_q),
		.led_index (s_tdata[9:2]),
		.red       (s_tdata[17:10]),
		.green     (s_tdata[25:18]),
		.blue      (s_tdata[33:26]),
		.led_count (s_tdata[41:34]),
		.stat      (stat),
		.line_nxt  (line_nxt)
	);

	assign res.line_level = line_nxt;
	assign res.busy_res = busy;
	assign res.frame_done = done;

	// output register with one skid entry so an item can be taken under a stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
			out_q <= '0;
			skid_q <= '0;
		end else if (skid_v_q) begin
			if (pop) begin
				out_q <= skid_q;
				skid_v_q <= 1'b0;
			end
		end else if (acc && (!out_v_q || pop)) begin
			out_q <= res;
			out_v_q <= 1'b1;
		end else if (acc) begin
			skid_q <= res;
			skid_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {5'd0, out_q};

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held with empty output register");

	a_skid_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> !s_tready)
		else $error("input open while skid entry is full");

	a_item_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> m_tvalid)
		else $error("taken item left no result");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// testbench of the led chain serializer: command and tick items against a line level predictor
module tb;
	import rlcs_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_SEND = 2'd1,
		MODE_GAP  = 2'd2
	} chain_mode_t;

	// predicts the line level, busy and frame done flags of every item
	class chain_line_model;
		logic [23:0] colors [LED_DEPTH];
		logic [23:0] shreg;
		logic [7:0]  led_at;
		logic [7:0]  leds_in_frame;
		logic [4:0]  bit_at;
		logic [15:0] ticks;
		chain_mode_t mode;
		logic        level;
		cfg_t        cfg;
		res_t        levels_due [$];
		int          errors;

		function new();
			foreach (colors[i]) colors[i] = '0;
			shreg = '0;
			led_at = '0;
			leds_in_frame = '0;
			bit_at = '0;
			ticks = '0;
			mode = MODE_IDLE;
			level = 1'b0;
			cfg.zero_high = ZERO_HIGH_RST;
			cfg.one_high = ONE_HIGH_RST;
			cfg.period = PERIOD_RST;
			cfg.gap = GAP_RST;
			errors = 0;
		endfunction

		function void write_reg(reg_idx_t ri, logic [31:0] val);
			case (ri)
				REG_ZERO_HIGH: cfg.zero_high = val[7:0];
				REG_ONE_HIGH: cfg.one_high = val[7:0];
				REG_PERIOD: cfg.period = val[7:0];
				REG_GAP: cfg.gap = val[15:0];
			endcase
		endfunction

		function bit busy();
			return mode != MODE_IDLE;
		endfunction

		function int pending();
			return levels_due.size();
		endfunction

		function void accept_cmd(op_t op, logic [7:0] idx, logic [7:0] red, logic [7:0] green,
				logic [7:0] blue, logic [7:0] cnt);
			logic       done;
			logic [7:0] high;
			res_t       want;
			done = 1'b0;
			if (op == OP_TICK) begin
				case (mode)
					MODE_SEND: begin
						high = shreg[23] ? cfg.one_high : cfg.zero_high;
						level = (ticks < {8'd0, high});
						ticks = ticks + 16'd1;
						if (ticks >= {8'd0, cfg.period}) begin
							ticks = '0;
							shreg = shreg << 1;
							bit_at = bit_at + 5'd1;
							if (bit_at >= 5'd24) begin
								bit_at = '0;
								led_at = led_at + 8'd1;
								if (led_at >= leds_in_frame || led_at >= LED_DEPTH) begin
									mode = MODE_GAP;
									shreg = '0;
								end else begin
									shreg = colors[led_at];
								end
							end
						end
					end
					MODE_GAP: begin
						level = 1'b0;
						ticks = ticks + 16'd1;
						// gap of zero behaves as one tick
						if (ticks >= cfg.gap || ticks == 16'd0) begin
							ticks = '0;
							mode = MODE_IDLE;
							done = 1'b1;
						end
					end
					default: level = 1'b0;
				endcase
			end else if (mode == MODE_IDLE) begin
				if (op == OP_SET) begin
					if (idx < LED_DEPTH) colors[idx] = {green, red, blue};
				end else begin
					if (op == OP_CLEAR) foreach (colors[i]) colors[i] = '0;
					leds_in_frame = (cnt > LED_DEPTH) ? 8'(LED_DEPTH) : cnt;
					led_at = '0;
					bit_at = '0;
					ticks = '0;
					level = 1'b0;
					if (leds_in_frame == 8'd0) begin
						shreg = '0;
						mode = MODE_GAP;
					end else begin
						shreg = colors[0];
						mode = MODE_SEND;
					end
				end
			end
			want.line_level = level;
			want.busy_res = (mode != MODE_IDLE);
			want.frame_done = done;
			levels_due.push_back(want);
		endfunction

		function void check_output(logic [7:0] got);
			res_t want;
			if (levels_due.size() == 0) begin
				$display("%0t: result %b arrived with no item pending", $time, got);
				errors++;
				return;
			end
			want = levels_due.pop_front();
			if (got !== {5'd0, want}) begin
				$display("%0t: expected line_level %b busy_res %b frame_done %b, got %b %b %b pad %b",
					$time, want.line_level, want.busy_res, want.frame_done,
					got[0], got[1], got[2], got[7:3]);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // op[1:0], led_index, red, green, blue, led_count, zero pad
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // line_level, busy_res, frame_done, zero pad
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	chain_line_model chain;
	bit steady = 1'b0;
	int items_sent = 0;
	int cycles = 0;
	int random_start;

	rgb_led_chain_serializer_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result side with random stalls
	always @(posedge clk) begin
		if (m_tvalid && m_tready) chain.check_output(m_tdata);
		m_tready <= steady || ($urandom_range(99) >= 29);
	end

	task automatic send_item(input op_t op, input logic [7:0] idx, input logic [7:0] red,
			input logic [7:0] green, input logic [7:0] blue, input logic [7:0] cnt);
		while (!steady && $urandom_range(99) < 29) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, cnt, blue, green, red, idx, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		chain.accept_cmd(op, idx, red, green, blue, cnt);
		items_sent++;
	endtask

	task automatic apb_write(input reg_idx_t ri, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {ri, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		chain.write_reg(ri, val);
		@(posedge clk);
	endtask

	// reconfigure only once every result is back; the callers see to it that the frame is over
	task automatic set_config(input logic [7:0] zero_hi, input logic [7:0] one_hi,
			input logic [7:0] period, input logic [15:0] gap);
		s_tvalid <= 1'b0;
		while (chain.pending() != 0) @(posedge clk);
		apb_write(REG_ZERO_HIGH, {24'd0, zero_hi});
		apb_write(REG_ONE_HIGH, {24'd0, one_hi});
		apb_write(REG_PERIOD, {24'd0, period});
		apb_write(REG_GAP, {16'd0, gap});
	endtask

	// ticks until the frame and its gap are over, with ignored commands mixed in when noisy is set
	task automatic run_frame(input bit noisy);
		while (chain.busy()) begin
			if (noisy && $urandom_range(15) == 0)
				send_item(op_t'($urandom_range(0, 2)), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom));
			else
				send_item(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom));
		end
	endtask

	// a few colour writes, then mostly a show or clear of a bounded count, played out
	task automatic run_sequence(input int max_cnt);
		logic [7:0] cnt;
		logic [7:0] idx;
		op_t op;
		repeat ($urandom_range(0, 3)) begin
			idx = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
			send_item(OP_SET, idx, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		end
		if ($urandom_range(9) == 0)
			send_item(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom));
		cnt = ($urandom_range(3) == 0) ? 8'($urandom_range(0, max_cnt)) : 8'($urandom_range(0, 2));
		if ($urandom_range(9) == 0)
			op = op_t'($urandom_range(0, 3));
		else
			op = ($urandom_range(4) == 0) ? OP_CLEAR : OP_SHOW;
		send_item(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), cnt);
		run_frame(1'b1);
	endtask

	initial begin
		chain = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(8'd1, 8'd2, 8'd3, 16'd2);
		send_item(OP_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_item(OP_SET, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'd0);
		send_item(OP_SET, 8'd63, 8'h01, 8'h80, 8'h55, 8'hFF);
		send_item(OP_SET, 8'd64, 8'hFF, 8'hFF, 8'hFF, 8'd0);
		send_item(OP_SET, 8'hFF, 8'hAA, 8'hAA, 8'hAA, 8'd0);
		send_item(OP_SHOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		// commands during the gap are dropped
		send_item(OP_SET, 8'd1, 8'hFF, 8'hFF, 8'hFF, 8'd0);
		send_item(OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1);
		run_frame(1'b0);
		send_item(OP_SHOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd2);
		run_frame(1'b1);
		send_item(OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1);
		run_frame(1'b0);

		random_start = items_sent;
		steady = 1'b1;
		set_config(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
			8'($urandom_range(2, 5)), 16'($urandom_range(1, 6)));
		repeat (2) run_sequence(3);
		steady = 1'b0;
		while (items_sent - random_start < 300) begin
			set_config(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
				8'($urandom_range(0, 6)), 16'($urandom_range(0, 8)));
			repeat (2) run_sequence(3);
		end

		// high times at or past the period, the shortest period and gap, and a long gap
		set_config(8'd255, 8'd255, 8'd2, 16'd1);
		repeat (2) run_sequence(3);
		set_config(8'd1, 8'd255, 8'd1, 16'd0);
		repeat (2) run_sequence(3);
		set_config(8'd0, 8'd0, 8'd0, 16'd3);
		repeat (2) run_sequence(3);
		set_config(8'd4, 8'd5, 8'd5, 16'd1);
		run_sequence(1);
		set_config(8'd1, 8'd2, 8'd2, 16'h0100);
		send_item(OP_SHOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		run_frame(1'b0);

		s_tvalid <= 1'b0;
		while (chain.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (chain.errors == 0 && chain.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
